### hdl/assert_macros.svh
// Assertion macros used by the RTL of the Hadamard mixing block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/hdm_pkg.sv
// Types, constants and helper functions for the Hadamard mixing block.
package hdm_pkg;

	// Q1.23 coefficients, rounded to nearest.
	localparam logic signed [22:0] NORM_C  = 23'sd2965821;
	localparam logic signed [22:0] WNORM_C = 23'sd2965817;
	localparam logic signed [23:0] P70_C   = 24'sd5872026;
	localparam logic signed [23:0] P60_C   = 24'sd5033165;
	localparam logic signed [23:0] P40_C   = 24'sd3355443;
	localparam logic signed [23:0] P50_C   = 24'sd4194304;
	localparam logic signed [23:0] P30_C   = 24'sd2516582;
	localparam logic signed [23:0] P80_C   = 24'sd6710886;

	// Configuration port.
	localparam int unsigned ADDR_W     = 3;
	localparam logic        REG_GAIN   = 1'b0;
	localparam logic [15:0] GAIN_RESET = 16'd32768;

	// One stereo frame with its eight delay-line taps.
	typedef struct packed {
		logic signed [23:0] in_left;
		logic signed [23:0] in_right;
		logic signed [23:0] tap_0;
		logic signed [23:0] tap_1;
		logic signed [23:0] tap_2;
		logic signed [23:0] tap_3;
		logic signed [23:0] tap_4;
		logic signed [23:0] tap_5;
		logic signed [23:0] tap_6;
		logic signed [23:0] tap_7;
	} in_item_t;

	// Delay-line write values and the stereo output.
	typedef struct packed {
		logic signed [23:0] write_0;
		logic signed [23:0] write_1;
		logic signed [23:0] write_2;
		logic signed [23:0] write_3;
		logic signed [23:0] write_4;
		logic signed [23:0] write_5;
		logic signed [23:0] write_6;
		logic signed [23:0] write_7;
		logic signed [23:0] out_left;
		logic signed [23:0] out_right;
	} out_item_t;

	// Clamp a wide sum to the signed 24-bit range.
	function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sd8388607) begin
			r = 24'sd8388607;
		end else if (v < -28'sd8388608) begin
			r = -24'sd8388608;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

### hdl/hadamard_diffuser_mix.sv
// Top level: eight-point Hadamard diffuser with input injection and stereo output.
//
//   Channel  Signals                               Direction  Content
//   frame    frame_valid, frame_ready, frame       in         stereo input and eight taps
//   mix      mix_valid, mix_ready, mix             out        eight write values and stereo out
//   apb      psel, penable, pwrite, paddr, pwdata  in         feedback gain register
//
// Seven register stages; when the output side is not stalled, a result is offered once
// its item has passed through stages 1 to 7. One item can enter in every cycle while
// the output side is not stalled.
// The stages hold the three butterfly levels, coefficient multiply, rounding, gain
// multiply and final rounding with saturation, each in a stage of its own.
// Each stage holds its item when the next one is full and stalled, so bubbles close up
// and nothing is lost or repeated. Reset clears the valid bits and sets the gain to 0.5.
`include "assert_macros.svh"

module hadamard_diffuser_mix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      frame_valid,
	output logic                      frame_ready,
	input  hdm_pkg::in_item_t         frame,
	output logic                      mix_valid,
	input  logic                      mix_ready,
	output hdm_pkg::out_item_t        mix
);
	import hdm_pkg::*;

	// Configuration register.
	logic [15:0] gain_q;
	logic        cfg_wr;
	logic        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_wr && cfg_idx == REG_GAIN) begin
			gain_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_GAIN: prdata = {16'd0, gain_q};
			default:  prdata = '0;
		endcase
	end

	// Stage valid bits and the enables that let each stage advance.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = ~v_s7 | mix_ready;
	assign en6 = ~v_s6 | en7;
	assign en5 = ~v_s5 | en6;
	assign en4 = ~v_s4 | en5;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign frame_ready = en1;
	assign mix_valid   = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= frame_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: first butterfly level on the taps.
	logic signed [23:0] t [8];
	logic signed [24:0] a_s1 [8];
	logic signed [23:0] l_s1, r_s1;

	assign t[0] = frame.tap_0;
	assign t[1] = frame.tap_1;
	assign t[2] = frame.tap_2;
	assign t[3] = frame.tap_3;
	assign t[4] = frame.tap_4;
	assign t[5] = frame.tap_5;
	assign t[6] = frame.tap_6;
	assign t[7] = frame.tap_7;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 4; i++) begin
				a_s1[2*i]   <= 25'(t[2*i]) + 25'(t[2*i+1]);
				a_s1[2*i+1] <= 25'(t[2*i]) - 25'(t[2*i+1]);
			end
			l_s1 <= frame.in_left;
			r_s1 <= frame.in_right;
		end
	end

	// Stage 2: second butterfly level and the two signed tap sums for the wet path.
	logic signed [25:0] b_s2 [8];
	logic signed [26:0] wl_s2, wr_s2;
	logic signed [23:0] l_s2, r_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			b_s2[0] <= 26'(a_s1[0]) + 26'(a_s1[2]);
			b_s2[1] <= 26'(a_s1[1]) + 26'(a_s1[3]);
			b_s2[2] <= 26'(a_s1[0]) - 26'(a_s1[2]);
			b_s2[3] <= 26'(a_s1[1]) - 26'(a_s1[3]);
			b_s2[4] <= 26'(a_s1[4]) + 26'(a_s1[6]);
			b_s2[5] <= 26'(a_s1[5]) + 26'(a_s1[7]);
			b_s2[6] <= 26'(a_s1[4]) - 26'(a_s1[6]);
			b_s2[7] <= 26'(a_s1[5]) - 26'(a_s1[7]);
			wl_s2 <= 27'(a_s1[0]) - 27'(a_s1[3]) - 27'(a_s1[5]) + 27'(a_s1[7]);
			wr_s2 <= 27'(a_s1[3]) - 27'(a_s1[1]) + 27'(a_s1[4]) - 27'(a_s1[7]);
			l_s2 <= l_s1;
			r_s2 <= r_s1;
		end
	end

	// Stage 3: last butterfly level.
	logic signed [26:0] f_s3 [8];
	logic signed [26:0] wl_s3, wr_s3;
	logic signed [23:0] l_s3, r_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < 4; i++) begin
				f_s3[i]   <= 27'(b_s2[i]) + 27'(b_s2[i+4]);
				f_s3[i+4] <= 27'(b_s2[i]) - 27'(b_s2[i+4]);
			end
			wl_s3 <= wl_s2;
			wr_s3 <= wr_s2;
			l_s3  <= l_s2;
			r_s3  <= r_s2;
		end
	end

	// Stage 4: coefficient products for the transform, the wet sums and the injections.
	logic signed [49:0] ph_s4 [8];
	logic signed [49:0] pwl_s4, pwr_s4;
	logic signed [47:0] pl70_s4, pl40_s4, pl30_s4;
	logic signed [47:0] pr70_s4, pr60_s4, pr50_s4, pr80_s4;
	logic signed [23:0] l_s4, r_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int i = 0; i < 8; i++) begin
				ph_s4[i] <= 50'(f_s3[i]) * 50'(NORM_C);
			end
			pwl_s4  <= 50'(wl_s3) * 50'(WNORM_C);
			pwr_s4  <= 50'(wr_s3) * 50'(WNORM_C);
			pl70_s4 <= 48'(l_s3) * 48'(P70_C);
			pl40_s4 <= 48'(l_s3) * 48'(P40_C);
			pl30_s4 <= 48'(l_s3) * 48'(P30_C);
			pr70_s4 <= 48'(r_s3) * 48'(P70_C);
			pr60_s4 <= 48'(r_s3) * 48'(P60_C);
			pr50_s4 <= 48'(r_s3) * 48'(P50_C);
			pr80_s4 <= 48'(r_s3) * 48'(P80_C);
			l_s4 <= l_s3;
			r_s4 <= r_s3;
		end
	end

	// Stage 5: round the products to Q1.23 and form the injection terms.
	localparam logic signed [49:0] HALF50 = 50'sd4194304;
	localparam logic signed [47:0] HALF48 = 48'sd4194304;

	logic signed [49:0] rh   [8];
	logic signed [49:0] rwl, rwr;
	logic signed [47:0] rl70, rl40, rl30, rr70, rr60, rr50, rr80;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rh[i] = (ph_s4[i] + HALF50) >>> 23;
		end
		rwl  = (pwl_s4 + HALF50) >>> 23;
		rwr  = (pwr_s4 + HALF50) >>> 23;
		rl70 = (pl70_s4 + HALF48) >>> 23;
		rl40 = (pl40_s4 + HALF48) >>> 23;
		rl30 = (pl30_s4 + HALF48) >>> 23;
		rr70 = (pr70_s4 + HALF48) >>> 23;
		rr60 = (pr60_s4 + HALF48) >>> 23;
		rr50 = (pr50_s4 + HALF48) >>> 23;
		rr80 = (pr80_s4 + HALF48) >>> 23;
	end

	logic signed [25:0] h_s5 [8];
	logic signed [25:0] wl_s5, wr_s5;
	logic signed [24:0] inj_s5 [8];
	logic signed [24:0] dl_s5, dr_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int i = 0; i < 8; i++) begin
				h_s5[i] <= rh[i][25:0];
			end
			wl_s5     <= rwl[25:0];
			wr_s5     <= rwr[25:0];
			inj_s5[0] <= 25'(l_s4);
			inj_s5[1] <= 25'(r_s4);
			inj_s5[2] <= -rl70[24:0];
			inj_s5[3] <= rr60[24:0];
			inj_s5[4] <= rl40[24:0];
			inj_s5[5] <= -rr50[24:0];
			inj_s5[6] <= rl30[24:0];
			inj_s5[7] <= rr80[24:0];
			dl_s5     <= rl70[24:0];
			dr_s5     <= rr70[24:0];
		end
	end

	// Stage 6: feedback gain on the transformed taps and the wet weight.
	logic signed [16:0] gain_sx;
	logic signed [42:0] pg_s6 [8];
	logic signed [48:0] pwl_s6, pwr_s6;
	logic signed [24:0] inj_s6 [8];
	logic signed [24:0] dl_s6, dr_s6;

	assign gain_sx = signed'({1'b0, gain_q});

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int i = 0; i < 8; i++) begin
				pg_s6[i]  <= 43'(h_s5[i]) * 43'(gain_sx);
				inj_s6[i] <= inj_s5[i];
			end
			pwl_s6 <= 49'(wl_s5) * 49'(P30_C);
			pwr_s6 <= 49'(wr_s5) * 49'(P30_C);
			dl_s6  <= dl_s5;
			dr_s6  <= dr_s5;
		end
	end

	// Stage 7: final rounding, the sums and saturation into the output register.
	localparam logic signed [42:0] HALF43 = 43'sd32768;
	localparam logic signed [48:0] HALF49 = 49'sd4194304;

	logic signed [42:0] rg [8];
	logic signed [48:0] rwl2, rwr2;
	logic signed [27:0] sum_w [8];
	logic signed [27:0] sum_l, sum_r;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rg[i]    = (pg_s6[i] + HALF43) >>> 16;
			sum_w[i] = 28'(rg[i]) + 28'(inj_s6[i]);
		end
		rwl2  = (pwl_s6 + HALF49) >>> 23;
		rwr2  = (pwr_s6 + HALF49) >>> 23;
		sum_l = 28'(dl_s6) + 28'(rwl2);
		sum_r = 28'(dr_s6) + 28'(rwr2);
	end

	out_item_t res_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			res_s7.write_0   <= sat24(sum_w[0]);
			res_s7.write_1   <= sat24(sum_w[1]);
			res_s7.write_2   <= sat24(sum_w[2]);
			res_s7.write_3   <= sat24(sum_w[3]);
			res_s7.write_4   <= sat24(sum_w[4]);
			res_s7.write_5   <= sat24(sum_w[5]);
			res_s7.write_6   <= sat24(sum_w[6]);
			res_s7.write_7   <= sat24(sum_w[7]);
			res_s7.out_left  <= sat24(sum_l);
			res_s7.out_right <= sat24(sum_r);
		end
	end

	assign mix = res_s7;

	// The pipeline refuses an item only when every stage holds one.
	`ASSERT_SAME(a_full_when_blocked, clk, arst_n, !frame_ready, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7)
	// A ready consumer always lets a new item in.
	`ASSERT_SAME(a_ready_passes, clk, arst_n, mix_ready, frame_ready)
	// A gain write lands in the register.
	`ASSERT_NEXT(a_gain_written, clk, arst_n, cfg_wr && cfg_idx == REG_GAIN, gain_q == $past(pwdata[15:0]))

endmodule
